FILE: rtl/core/trapezoidal_setpoint_profiler_macros.svh
// Assertion macros for the trapezoidal setpoint profiler.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef TRAPEZOIDAL_SETPOINT_PROFILER_MACROS_SVH
`define TRAPEZOIDAL_SETPOINT_PROFILER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define TSP_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("tsp assertion failed");

// Next-cycle implication, disabled during reset
`define TSP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("tsp assertion failed");

`endif

FILE: rtl/core/tsp_pkg.sv
// Shared constants, widths and command structs of the setpoint profiler.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package tsp_pkg;

	localparam int FRAC_BITS = 16;
	localparam int POS_W     = 32;
	localparam int TIME_W    = 32;
	localparam int STEP_W    = 20;
	localparam int LIM_W     = 31;
	localparam int DIST_W    = POS_W + 1;
	localparam int NUM_W     = 65;
	localparam int REM_W     = 35;
	localparam int ACC_W     = 96;
	localparam int OPD_W     = 33;

	// Retarget threshold of 0.01 in LSBs
	localparam logic [DIST_W-1:0] RETARGET_THR = DIST_W'(((64'd1 << FRAC_BITS) + 64'd50) / 64'd100);

	// Register reset values and the limits derived from them
	localparam logic [STEP_W-1:0] RST_STEP = 20'd3277;
	localparam logic [LIM_W-1:0]  RST_VEL  = 31'd131072;
	localparam logic [LIM_W-1:0]  RST_ACC  = 31'd32768;
	localparam logic [63:0] RST_AET64 = ({33'd0, RST_VEL} << FRAC_BITS) / {33'd0, RST_ACC};
	localparam logic [63:0] RST_AD64  = ({33'd0, RST_VEL} * {33'd0, RST_VEL}) /
		({33'd0, RST_ACC} << 1);
	localparam logic [TIME_W-1:0] RST_AET = RST_AET64[TIME_W-1:0];
	localparam logic [POS_W-1:0]  RST_AD  = RST_AD64[POS_W-1:0];

	// Register indexes
	localparam logic [1:0] CFG_STEP_TIME = 2'd0;
	localparam logic [1:0] CFG_MAX_VEL   = 2'd1;
	localparam logic [1:0] CFG_MAX_ACC   = 2'd2;

	// Iteration counts of the shared divide / root unit
	localparam logic [6:0] DIV_STEPS  = 7'd65;
	localparam logic [6:0] SQRT_STEPS = 7'd32;

	typedef struct packed {
		logic start;
		logic sqrt;
	} iter_cmd_t;

	typedef struct packed {
		logic en;
		logic acc;
		logic hi;
	} mac_cmd_t;

endpackage

FILE: rtl/core/tsp_iter.sv
// Shared bit-serial divide / square-root unit: one quotient or root bit a cycle.
// Depends on tsp_pkg.
`timescale 1ns / 1ps
module tsp_iter import tsp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  iter_cmd_t        cmd,
	input  logic [NUM_W-1:0] num,
	input  logic [31:0]      den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);

	logic             busy_q;
	logic             mode_q;
	logic             done_q;
	logic [6:0]       cnt_q;
	logic [NUM_W-1:0] src_q;
	logic [NUM_W-1:0] quo_q;
	logic [REM_W-1:0] rem_q;
	logic [31:0]      den_q;
	logic [REM_W-1:0] rem_sh;
	logic [REM_W-1:0] trial;
	logic [REM_W-1:0] rem_dif;
	logic             ge;

	// Bring in the next digit and trial-subtract
	always_comb begin
		if (mode_q) begin
			rem_sh = {rem_q[REM_W-3:0], src_q[NUM_W-1:NUM_W-2]};
			trial  = {quo_q[REM_W-3:0], 2'b01};
		end else begin
			rem_sh = {rem_q[REM_W-2:0], src_q[NUM_W-1]};
			trial  = {3'b000, den_q};
		end
		ge      = rem_sh >= trial;
		rem_dif = rem_sh - trial;
	end

	// Control: run for a fixed count, pulse done at the end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			mode_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
			mode_q <= cmd.sqrt;
			done_q <= 1'b0;
			cnt_q  <= cmd.sqrt ? SQRT_STEPS : DIV_STEPS;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 7'd1;
			if (cnt_q == 7'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Datapath: shift source, update remainder and result
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			src_q <= cmd.sqrt ? {num[NUM_W-2:0], 1'b0} : num;
			rem_q <= '0;
			quo_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? rem_dif : rem_sh;
			quo_q <= {quo_q[NUM_W-2:0], ge};
			src_q <= mode_q ? {src_q[NUM_W-3:0], 2'b00} : {src_q[NUM_W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

FILE: rtl/core/tsp_mac.sv
// Shared multiply-accumulate unit: one 33x33 product a cycle into a 96-bit sum.
// Depends on tsp_pkg.
`timescale 1ns / 1ps
module tsp_mac import tsp_pkg::*; (
	input  logic             clk,
	input  mac_cmd_t         cmd,
	input  logic [OPD_W-1:0] opa,
	input  logic [OPD_W-1:0] opb,
	output logic [ACC_W-1:0] acc
);

	logic [2*OPD_W-1:0] prod;
	logic [ACC_W-1:0]   addend;
	logic [ACC_W-1:0]   base;
	logic [ACC_W-1:0]   acc_q;

	// Place the product in the low or upper word
	always_comb begin
		prod   = opa * opb;
		addend = cmd.hi ? {prod[63:0], 32'd0} : {30'd0, prod};
		base   = cmd.acc ? acc_q : '0;
	end

	// Load or accumulate
	always_ff @(posedge clk) begin
		if (cmd.en) begin
			acc_q <= base + addend;
		end
	end

	assign acc = acc_q;

endmodule

FILE: rtl/core/trapezoidal_setpoint_profiler.sv
// On a retarget, a tick runs the bit-serial divide/root unit (two 65-step divides and
// two 32-step roots); a tick without a retarget skips them.
// A write of max_velocity or max_acceleration runs one divide pair.
// A new tick is taken only in idle, after the last one is done; it is taken while a result waits.
// Reset (arst_n, async): registers to their reset values, limits preloaded.
`timescale 1ns / 1ps
`include "trapezoidal_setpoint_profiler_macros.svh"
module trapezoidal_setpoint_profiler import tsp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [LIM_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [POS_W-1:0]  target_position,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [POS_W-1:0]  reference_position
);

	localparam logic [4:0] ST_IDLE    = 5'd0;
	localparam logic [4:0] ST_CHECK   = 5'd1;
	localparam logic [4:0] ST_L_MUL   = 5'd2;
	localparam logic [4:0] ST_L_DIV1  = 5'd3;
	localparam logic [4:0] ST_L_DIV1W = 5'd4;
	localparam logic [4:0] ST_L_DIV2  = 5'd5;
	localparam logic [4:0] ST_L_DIV2W = 5'd6;
	localparam logic [4:0] ST_R_DIV1  = 5'd7;
	localparam logic [4:0] ST_R_DIV1W = 5'd8;
	localparam logic [4:0] ST_R_MET   = 5'd9;
	localparam logic [4:0] ST_R_DIV2  = 5'd10;
	localparam logic [4:0] ST_R_DIV2W = 5'd11;
	localparam logic [4:0] ST_R_SQ1   = 5'd12;
	localparam logic [4:0] ST_R_SQ1W  = 5'd13;
	localparam logic [4:0] ST_R_MUL   = 5'd14;
	localparam logic [4:0] ST_R_SQ2   = 5'd15;
	localparam logic [4:0] ST_R_SQ2W  = 5'd16;
	localparam logic [4:0] ST_ADV     = 5'd17;
	localparam logic [4:0] ST_SEL     = 5'd18;
	localparam logic [4:0] ST_H1A     = 5'd19;
	localparam logic [4:0] ST_H1B     = 5'd20;
	localparam logic [4:0] ST_H1C     = 5'd21;
	localparam logic [4:0] ST_H1D     = 5'd22;
	localparam logic [4:0] ST_LIN     = 5'd23;
	localparam logic [4:0] ST_H2B     = 5'd24;
	localparam logic [4:0] ST_H2C     = 5'd25;
	localparam logic [4:0] ST_H2D     = 5'd26;
	localparam logic [4:0] ST_SUM     = 5'd27;
	localparam logic [4:0] ST_DIFF    = 5'd28;
	localparam logic [4:0] ST_OUT     = 5'd29;

	logic [4:0]        state_q;
	logic [STEP_W-1:0] step_q;
	logic [LIM_W-1:0]  vel_q;
	logic [LIM_W-1:0]  acc_lim_q;
	logic [LIM_W-1:0]  v_eff;
	logic [LIM_W-1:0]  a_eff;
	logic [POS_W-1:0]  tgt_q;
	logic [POS_W-1:0]  held_q;
	logic [POS_W-1:0]  start_q;
	logic [DIST_W-1:0] dist_q;
	logic              dir_neg_q;
	logic [TIME_W-1:0] elapsed_q;
	logic [TIME_W-1:0] aet_q;
	logic [POS_W-1:0]  ad_q;
	logic [TIME_W-1:0] dst_q;
	logic [TIME_W-1:0] met_q;
	logic [TIME_W-1:0] rht_q;
	logic [TIME_W-1:0] rpv_q;
	logic              trap_q;
	logic [63:0]       tmp_q;
	logic [31:0]       tthi_q;
	logic [TIME_W-1:0] x1_q;
	logic [TIME_W-1:0] x2_q;
	logic [31:0]       m1_q;
	logic [31:0]       m2_q;
	logic              use_ad_q;
	logic              full_q;
	logic [62:0]       h1_q;
	logic [62:0]       h2_q;
	logic [47:0]       lin_q;
	logic [63:0]       sum_q;
	logic [63:0]       p_q;
	logic              out_valid_q;
	logic [POS_W-1:0]  out_q;

	logic              in_take;
	logic              cfg_take;
	logic [DIST_W-1:0] diff;
	logic [DIST_W-1:0] mag;
	logic [TIME_W:0]   met_sum;
	logic [TIME_W:0]   adv_sum;
	logic              out_free;
	logic [DIST_W-1:0] p_clamp;

	iter_cmd_t         iter_cmd;
	logic [NUM_W-1:0]  iter_num;
	logic [31:0]       iter_den;
	logic              iter_done;
	logic [NUM_W-1:0]  iter_quo;
	mac_cmd_t          mac_cmd;
	logic [OPD_W-1:0]  mac_a;
	logic [OPD_W-1:0]  mac_b;
	logic [ACC_W-1:0]  mac_acc;

	// Handshakes: configuration wins in idle
	assign cfg_ready = (state_q == ST_IDLE);
	assign cfg_take  = cfg_valid && cfg_ready;
	assign in_stall  = (state_q != ST_IDLE) || cfg_valid;
	assign in_take   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	// A zero limit acts as one
	assign v_eff = (vel_q == '0) ? LIM_W'(1) : vel_q;
	assign a_eff = (acc_lim_q == '0) ? LIM_W'(1) : acc_lim_q;

	// Retarget test and sums
	always_comb begin
		diff    = {tgt_q[POS_W-1], tgt_q} - {held_q[POS_W-1], held_q};
		mag     = diff[DIST_W-1] ? (~diff + DIST_W'(1)) : diff;
		met_sum = {1'b0, aet_q} + {1'b0, dst_q};
		adv_sum = {1'b0, elapsed_q} + {13'd0, step_q};
		p_clamp = (p_q > {31'd0, dist_q}) ? dist_q : p_q[DIST_W-1:0];
	end

	// Drive the shared divide / root unit
	always_comb begin
		iter_cmd = '0;
		iter_num = '0;
		iter_den = '0;
		unique case (state_q)
			ST_L_DIV1: begin
				iter_cmd.start = 1'b1;
				iter_num = {3'd0, mac_acc[61:0]};
				iter_den = {a_eff, 1'b0};
			end
			ST_L_DIV2: begin
				iter_cmd.start = 1'b1;
				iter_num = {18'd0, v_eff, 16'd0};
				iter_den = {1'b0, a_eff};
			end
			ST_R_DIV1: begin
				iter_cmd.start = 1'b1;
				iter_num = {16'd0, dist_q, 16'd0};
				iter_den = {1'b0, v_eff};
			end
			ST_R_DIV2: begin
				iter_cmd.start = 1'b1;
				iter_num = {dist_q, 32'd0};
				iter_den = {1'b0, a_eff};
			end
			ST_R_SQ1: begin
				iter_cmd.start = 1'b1;
				iter_cmd.sqrt  = 1'b1;
				iter_num = {1'b0, tmp_q};
			end
			ST_R_SQ2: begin
				iter_cmd.start = 1'b1;
				iter_cmd.sqrt  = 1'b1;
				iter_num = {1'b0, mac_acc[63:0]};
			end
			default: begin
				iter_cmd = '0;
			end
		endcase
	end

	// Drive the shared multiply-accumulate unit
	always_comb begin
		mac_cmd = '0;
		mac_a   = '0;
		mac_b   = '0;
		unique case (state_q)
			ST_L_MUL: begin
				mac_cmd.en = 1'b1;
				mac_a = {2'b00, v_eff};
				mac_b = {2'b00, v_eff};
			end
			ST_R_MUL: begin
				mac_cmd.en = 1'b1;
				mac_a = dist_q;
				mac_b = {2'b00, a_eff};
			end
			ST_H1A: begin
				mac_cmd.en = 1'b1;
				mac_a = {1'b0, x1_q};
				mac_b = {1'b0, x1_q};
			end
			ST_H1D: begin
				mac_cmd.en = 1'b1;
				mac_a = {1'b0, m1_q};
				mac_b = {1'b0, m2_q};
			end
			ST_LIN: begin
				mac_cmd.en = 1'b1;
				mac_a = {1'b0, x2_q};
				mac_b = {1'b0, x2_q};
			end
			ST_H1B, ST_H2B: begin
				mac_cmd.en = 1'b1;
				mac_a = {2'b00, a_eff};
				mac_b = {1'b0, mac_acc[31:0]};
			end
			ST_H1C, ST_H2C: begin
				mac_cmd.en  = 1'b1;
				mac_cmd.acc = 1'b1;
				mac_cmd.hi  = 1'b1;
				mac_a = {2'b00, a_eff};
				mac_b = {1'b0, tthi_q};
			end
			default: begin
				mac_cmd = '0;
			end
		endcase
	end

	tsp_iter u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (iter_cmd),
		.num    (iter_num),
		.den    (iter_den),
		.done   (iter_done),
		.quo    (iter_quo)
	);

	tsp_mac u_mac (
		.clk (clk),
		.cmd (mac_cmd),
		.opa (mac_a),
		.opb (mac_b),
		.acc (mac_acc)
	);

	// Sequencer and profile state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= RST_STEP;
			vel_q       <= RST_VEL;
			acc_lim_q   <= RST_ACC;
			held_q      <= '0;
			start_q     <= '0;
			dist_q      <= '0;
			dir_neg_q   <= 1'b0;
			elapsed_q   <= '0;
			aet_q       <= RST_AET;
			ad_q        <= RST_AD;
			dst_q       <= '0;
			met_q       <= '0;
			rht_q       <= '0;
			rpv_q       <= '0;
			trap_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != ST_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cfg_take) begin
						unique case (cfg_index)
							CFG_STEP_TIME: step_q <= cfg_data[STEP_W-1:0];
							CFG_MAX_VEL: begin
								vel_q   <= cfg_data;
								state_q <= ST_L_MUL;
							end
							CFG_MAX_ACC: begin
								acc_lim_q <= cfg_data;
								state_q   <= ST_L_MUL;
							end
							default: state_q <= ST_IDLE;
						endcase
					end else if (in_take) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (mag > RETARGET_THR) begin
						start_q   <= held_q;
						held_q    <= tgt_q;
						dist_q    <= mag;
						dir_neg_q <= diff[DIST_W-1];
						elapsed_q <= '0;
						state_q   <= ST_R_DIV1;
					end else begin
						state_q <= ST_ADV;
					end
				end
				ST_L_MUL:  state_q <= ST_L_DIV1;
				ST_L_DIV1: state_q <= ST_L_DIV1W;
				ST_L_DIV1W: begin
					if (iter_done) begin
						ad_q    <= (iter_quo[NUM_W-1:POS_W] != '0) ? '1 : iter_quo[POS_W-1:0];
						state_q <= ST_L_DIV2;
					end
				end
				ST_L_DIV2: state_q <= ST_L_DIV2W;
				ST_L_DIV2W: begin
					if (iter_done) begin
						aet_q   <= (iter_quo[NUM_W-1:TIME_W] != '0) ? '1 : iter_quo[TIME_W-1:0];
						state_q <= ST_IDLE;
					end
				end
				ST_R_DIV1: state_q <= ST_R_DIV1W;
				ST_R_DIV1W: begin
					if (iter_done) begin
						dst_q   <= (iter_quo[NUM_W-1:TIME_W] != '0) ? '1 : iter_quo[TIME_W-1:0];
						state_q <= ST_R_MET;
					end
				end
				ST_R_MET: begin
					met_q   <= met_sum[TIME_W] ? '1 : met_sum[TIME_W-1:0];
					state_q <= ST_R_DIV2;
				end
				ST_R_DIV2: state_q <= ST_R_DIV2W;
				ST_R_DIV2W: begin
					if (iter_done) begin
						state_q <= ST_R_SQ1;
					end
				end
				ST_R_SQ1:  state_q <= ST_R_SQ1W;
				ST_R_SQ1W: begin
					if (iter_done) begin
						rht_q   <= iter_quo[TIME_W-1:0];
						state_q <= ST_R_MUL;
					end
				end
				ST_R_MUL:  state_q <= ST_R_SQ2;
				ST_R_SQ2:  state_q <= ST_R_SQ2W;
				ST_R_SQ2W: begin
					if (iter_done) begin
						rpv_q   <= iter_quo[TIME_W-1:0];
						trap_q  <= dist_q > {ad_q, 1'b0};
						state_q <= ST_ADV;
					end
				end
				ST_ADV: begin
					elapsed_q <= adv_sum[TIME_W] ? '1 : adv_sum[TIME_W-1:0];
					state_q   <= ST_SEL;
				end
				ST_SEL:  state_q <= ST_H1A;
				ST_H1A:  state_q <= ST_H1B;
				ST_H1B:  state_q <= ST_H1C;
				ST_H1C:  state_q <= ST_H1D;
				ST_H1D:  state_q <= ST_LIN;
				ST_LIN:  state_q <= ST_H2B;
				ST_H2B:  state_q <= ST_H2C;
				ST_H2C:  state_q <= ST_H2D;
				ST_H2D:  state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_DIFF;
				ST_DIFF: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers of the tick
	always_ff @(posedge clk) begin
		if (in_take) begin
			tgt_q <= target_position;
		end
		// Hold the square-root radicand, saturated to 64 bits
		if (state_q == ST_R_DIV2W && iter_done) begin
			tmp_q <= iter_quo[NUM_W-1] ? '1 : iter_quo[63:0];
		end
		// Pick the phase and its operands
		if (state_q == ST_SEL) begin
			x1_q     <= '0;
			x2_q     <= '0;
			m1_q     <= '0;
			m2_q     <= '0;
			use_ad_q <= 1'b0;
			full_q   <= 1'b0;
			if (trap_q) begin
				if (elapsed_q < aet_q) begin
					x1_q <= elapsed_q;
				end else if (elapsed_q < dst_q) begin
					use_ad_q <= 1'b1;
					m1_q     <= {1'b0, v_eff};
					m2_q     <= elapsed_q - aet_q;
				end else if (elapsed_q < met_q) begin
					use_ad_q <= 1'b1;
					m1_q     <= {1'b0, v_eff};
					m2_q     <= elapsed_q - aet_q;
					x2_q     <= elapsed_q - dst_q;
				end else begin
					full_q <= 1'b1;
				end
			end else begin
				if (elapsed_q < rht_q) begin
					x1_q <= elapsed_q;
				end else if ({1'b0, elapsed_q} <= {rht_q, 1'b0}) begin
					x1_q <= rht_q;
					m1_q <= rpv_q;
					m2_q <= elapsed_q - rht_q;
					x2_q <= elapsed_q - rht_q;
				end else begin
					full_q <= 1'b1;
				end
			end
		end
		if (state_q == ST_H1B || state_q == ST_H2B) begin
			tthi_q <= mac_acc[63:32];
		end
		if (state_q == ST_H1D) begin
			h1_q <= mac_acc[95:33];
		end
		if (state_q == ST_LIN) begin
			lin_q <= mac_acc[63:16];
		end
		if (state_q == ST_H2D) begin
			h2_q <= mac_acc[95:33];
		end
		if (state_q == ST_SUM) begin
			sum_q <= {1'b0, h1_q} + {16'd0, lin_q} + (use_ad_q ? {32'd0, ad_q} : 64'd0);
		end
		// Drop below zero to zero
		if (state_q == ST_DIFF) begin
			p_q <= (sum_q > {1'b0, h2_q}) ? (sum_q - {1'b0, h2_q}) : 64'd0;
		end
		// Clamp to the distance and apply the direction
		if (state_q == ST_OUT && out_free) begin
			if (full_q) begin
				out_q <= dir_neg_q ? (start_q - dist_q[POS_W-1:0])
					: (start_q + dist_q[POS_W-1:0]);
			end else begin
				out_q <= dir_neg_q ? (start_q - p_clamp[POS_W-1:0])
					: (start_q + p_clamp[POS_W-1:0]);
			end
		end
	end

	assign out_valid          = out_valid_q;
	assign reference_position = out_q;

	`TSP_ASSERT_NEXT(a_busy_after_request, in_take, state_q != ST_IDLE)
	`TSP_ASSERT_IMPL(a_cfg_not_with_request, cfg_take, !in_take)
	`TSP_ASSERT_NEXT(a_time_monotonic, state_q == ST_ADV, elapsed_q >= $past(elapsed_q))
	`TSP_ASSERT_IMPL(a_iter_done_in_wait, iter_done && state_q != ST_IDLE,
		state_q == ST_L_DIV1W || state_q == ST_L_DIV2W || state_q == ST_R_DIV1W ||
		state_q == ST_R_DIV2W || state_q == ST_R_SQ1W || state_q == ST_R_SQ2W)

endmodule
